[rtl/lbct_pkg.sv]
// Shared types for the LRU block cache tag controller.
// No dependencies; imported by lbct_tags and lru_block_cache_tags.
`default_nettype none

package lbct_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_CLEAR = 3'b100
    } lbct_state_t;

    typedef struct packed
    {
        logic clear_all;
        logic fill;
    } lbct_tag_ctl_t;

endpackage

`default_nettype wire

[rtl/lru_block_cache_tags.sv]
// A lookup scans the recency list from the front and raises m_tvalid when a tag hits or,
// on a miss, when the scan reaches the least recently used position; an invalidate raises it from ST_CLEAR.
// One item at a time; the scan checks one tag per cycle through the single comparator and
// holds while an earlier result waits on m_tready.
// Reset: all slots invalid, recency position i holds slot i; no clearing pass.
// Depends on lbct_pkg, lbct_recency and lbct_tags. BLOCK_ENTRIES is a power of two.
`default_nettype none

module lru_block_cache_tags
#(
    parameter int NUM_SLOTS     = 16,
    parameter int BLOCK_ENTRIES = 256,
    parameter int ADDR_BITS     = 22
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // address
    input  wire logic [((ADDR_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  wire logic s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // hit, fill_needed, slot, offset, fill_block_start
    output logic [((2+$clog2(NUM_SLOTS)+$clog2(BLOCK_ENTRIES)+ADDR_BITS+7)/8)*8-1:0] m_tdata
);

    import lbct_pkg::*;

    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int OFFS_BITS = $clog2(BLOCK_ENTRIES);
    localparam int TAG_BITS  = ADDR_BITS - OFFS_BITS;
    localparam int RES_BITS  = 2 + SLOT_BITS + OFFS_BITS + ADDR_BITS;
    localparam int OUT_W     = ((RES_BITS + 7) / 8) * 8;
    localparam logic [SLOT_BITS-1:0] LAST_POS = SLOT_BITS'(NUM_SLOTS - 1);

    lbct_state_t          state_reg, state_next;
    logic [SLOT_BITS-1:0] pos_reg, pos_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    logic                 out_free;
    logic                 commit;
    logic                 mtf_en;
    logic                 match;
    logic [SLOT_BITS-1:0] cur_slot;
    lbct_tag_ctl_t        tag_ctl;
    logic [TAG_BITS-1:0]  cur_tag;
    logic [RES_BITS-1:0]  res_vec;
    logic                 res_hit;
    logic                 res_fill;
    logic [SLOT_BITS-1:0] res_slot;
    logic [OFFS_BITS-1:0] res_offs;
    logic [ADDR_BITS-1:0] res_start;

    assign cur_tag  = addr_reg[ADDR_BITS-1:OFFS_BITS];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    lbct_recency #(.NUM_SLOTS(NUM_SLOTS)) u_recency
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pos    (pos_reg),
        .mtf_en (mtf_en),
        .slot   (cur_slot)
    );

    lbct_tags #(.NUM_SLOTS(NUM_SLOTS), .TAG_BITS(TAG_BITS)) u_tags
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot       (cur_slot),
        .lookup_tag (cur_tag),
        .ctl        (tag_ctl),
        .match      (match)
    );

    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        commit            = 1'b0;
        mtf_en            = 1'b0;
        tag_ctl.clear_all = 1'b0;
        tag_ctl.fill      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pos_next = '0;
                if (s_tvalid)
                begin
                    state_next = s_tuser ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match || (pos_reg == LAST_POS))
                begin
                    if (out_free)
                    begin
                        commit       = 1'b1;
                        mtf_en       = 1'b1;
                        tag_ctl.fill = !match;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_reg + SLOT_BITS'(1);
                end
            end
            ST_CLEAR:
            begin
                if (out_free)
                begin
                    commit            = 1'b1;
                    tag_ctl.clear_all = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_hit   = (state_reg == ST_SCAN) && match;
        res_fill  = (state_reg == ST_SCAN) && !match;
        res_slot  = (state_reg == ST_SCAN) ? cur_slot : '0;
        res_offs  = (state_reg == ST_SCAN) ? addr_reg[OFFS_BITS-1:0] : '0;
        res_start = res_fill ? {cur_tag, {OFFS_BITS{1'b0}}} : '0;
        res_vec   = {res_start, res_offs, res_slot, res_fill, res_hit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (commit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            addr_reg <= s_tdata[ADDR_BITS-1:0];
        end
        if (commit)
        begin
            m_data_reg <= OUT_W'(res_vec);
        end
    end

`ifndef SYNTHESIS
    a_lookup_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> (state_reg == ST_SCAN) && (pos_reg == '0))
        else $error("lookup did not start the scan at the front");

    a_fill_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        tag_ctl.fill |-> (pos_reg == LAST_POS) && mtf_en)
        else $error("refill outside the least recently used position");

    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("result flags both hit and fill");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while an item is in work");

    a_commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> out_free)
        else $error("result overwrote an untaken result");
`endif

endmodule

`default_nettype wire

[rtl/lbct_recency.sv]
// Recency list: slot numbers from most recently used (position 0) to least recently used.
// Single read port at a position and a move-to-front update of that position.
// No dependencies.
`default_nettype none

module lbct_recency
#(
    parameter int NUM_SLOTS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [$clog2(NUM_SLOTS)-1:0] pos,
    input  wire logic                         mtf_en,
    output logic      [$clog2(NUM_SLOTS)-1:0] slot
);

    localparam int SLOT_BITS = $clog2(NUM_SLOTS);

    logic [SLOT_BITS-1:0] order_reg [NUM_SLOTS];

    assign slot = order_reg[pos];

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_pos
        if (i == 0)
        begin : g_front
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    order_reg[i] <= '0;
                end
                else if (mtf_en)
                begin
                    order_reg[i] <= order_reg[pos];
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    order_reg[i] <= SLOT_BITS'(i);
                end
                else if (mtf_en && (SLOT_BITS'(i) <= pos))
                begin
                    order_reg[i] <= order_reg[i-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/lbct_tags.sv]
// Slot tag and valid store with the shared tag comparator.
// Depends on lbct_pkg for the control struct.
`default_nettype none

module lbct_tags
#(
    parameter int NUM_SLOTS = 16,
    parameter int TAG_BITS  = 14
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]  slot,
    input  wire logic [TAG_BITS-1:0]           lookup_tag,
    input  wire lbct_pkg::lbct_tag_ctl_t       ctl,
    output logic                               match
);

    import lbct_pkg::*;

    logic [TAG_BITS-1:0]  tag_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;

    assign match = valid_reg[slot] && (tag_reg[slot] == lookup_tag);

    always_ff @(posedge clk)
    begin
        if (ctl.fill)
        begin
            tag_reg[slot] <= lookup_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear_all)
        begin
            valid_reg <= '0;
        end
        else if (ctl.fill)
        begin
            valid_reg[slot] <= 1'b1;
        end
    end

endmodule

`default_nettype wire
